// ===== src/flp_pkg.sv =====
package flp_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_FRAC_DEF   = 24;
	localparam int NUM_STAGES      = 4;
	localparam int IDX_W           = $clog2(NUM_STAGES);
	localparam int STATE_W         = 32;
	localparam int MA_W            = STATE_W + 1;
	localparam int SPLIT_W         = 20;
	localparam int FB_W            = 36;
	localparam int DRV_W           = 40;
	localparam int CFG_IDX_W       = 3;

	// reset coefficients at 24 fraction bits
	localparam logic [31:0] RST_STAGE_GAIN = 32'd1117530;
	localparam logic [31:0] RST_INPUT_GAIN = 32'd16777216;
	localparam logic [31:0] RST_RESONANCE  = 32'd0;
	localparam logic [31:0] RST_TAP_ONE    = 32'd4628;
	localparam logic [31:0] RST_TAP_TWO    = 32'd69480;
	localparam logic [31:0] RST_TAP_THREE  = 32'd1043087;
	localparam logic [31:0] RST_TAP_FOUR   = 32'd15659700;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STAGE_GAIN,
		REG_INPUT_GAIN,
		REG_RESONANCE,
		REG_TAP_ONE,
		REG_TAP_TWO,
		REG_TAP_THREE,
		REG_TAP_FOUR
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MA_ST,
		MA_FB_LO,
		MA_FB_HI,
		MA_DRV_LO,
		MA_DRV_HI,
		MA_DIFF
	} ma_sel_t;

	typedef enum logic [1:0] {
		MB_TAP,
		MB_RES,
		MB_GAIN,
		MB_STAGE
	} mb_sel_t;

	typedef enum logic [3:0] {
		PO_NONE,
		PO_LOAD,
		PO_FB_ACC,
		PO_ACC_LO,
		PO_ACC_HI,
		PO_DRIVE,
		PO_SIN,
		PO_V,
		PO_Y,
		PO_ST,
		PO_OUT
	} post_t;

	typedef struct packed {
		logic             mul_en;
		ma_sel_t          ma;
		mb_sel_t          mb;
		logic [IDX_W-1:0] idx;
		post_t            post;
	} flp_cmd_t;

	// rescale a 24-fraction-bit reset constant
	function automatic logic [31:0] coef_at(input logic [31:0] v24, input int frac);
		if (frac >= 24)
			return v24 << (frac - 24);
		return v24 >> (24 - frac);
	endfunction

	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[STATE_W-1:0];
	endfunction

endpackage

// ===== src/flp_if.sv =====
interface flp_in_if #(parameter int SAMPLE_BITS = flp_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface flp_out_if #(parameter int SAMPLE_BITS = flp_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

// ===== src/flp_ctrl.sv =====
module flp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_valid,
	output logic              feed_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output flp_pkg::flp_cmd_t cmd
);
	import flp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FB,
		S_RLO,
		S_RHI,
		S_RACC,
		S_DRV,
		S_GLO,
		S_GHI,
		S_GACC,
		S_SIN,
		S_SMUL,
		S_V,
		S_Y,
		S_ST,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       res_valid_q;
	logic       out_load;

	assign feed_ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign out_load   = (state_q == S_OUT) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (feed_valid) begin
						state_q <= S_FB;
						cnt_q   <= '0;
					end
				end
				S_FB: begin
					if (cnt_q == 3'(NUM_STAGES))
						state_q <= S_RLO;
					else
						cnt_q <= cnt_q + 3'd1;
				end
				S_RLO:  state_q <= S_RHI;
				S_RHI:  state_q <= S_RACC;
				S_RACC: state_q <= S_DRV;
				S_DRV:  state_q <= S_GLO;
				S_GLO:  state_q <= S_GHI;
				S_GHI:  state_q <= S_GACC;
				S_GACC: state_q <= S_SIN;
				S_SIN: begin
					state_q <= S_SMUL;
					cnt_q   <= '0;
				end
				S_SMUL: state_q <= S_V;
				S_V:    state_q <= S_Y;
				S_Y:    state_q <= S_ST;
				S_ST: begin
					if (cnt_q[IDX_W-1:0] == IDX_W'(NUM_STAGES - 1)) begin
						state_q <= S_OUT;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_SMUL;
					end
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_en = 1'b0;
		cmd.ma     = MA_ST;
		cmd.mb     = MB_TAP;
		cmd.idx    = cnt_q[IDX_W-1:0];
		cmd.post   = PO_NONE;
		unique case (state_q)
			S_IDLE: cmd.post = feed_valid ? PO_LOAD : PO_NONE;
			S_FB: begin
				cmd.mul_en = (cnt_q != 3'(NUM_STAGES));
				cmd.post   = (cnt_q != 3'd0) ? PO_FB_ACC : PO_NONE;
			end
			S_RLO: begin
				cmd.mul_en = 1'b1;
				cmd.ma     = MA_FB_LO;
				cmd.mb     = MB_RES;
			end
			S_RHI: begin
				cmd.mul_en = 1'b1;
				cmd.ma     = MA_FB_HI;
				cmd.mb     = MB_RES;
				cmd.post   = PO_ACC_LO;
			end
			S_RACC: cmd.post = PO_ACC_HI;
			S_DRV:  cmd.post = PO_DRIVE;
			S_GLO: begin
				cmd.mul_en = 1'b1;
				cmd.ma     = MA_DRV_LO;
				cmd.mb     = MB_GAIN;
			end
			S_GHI: begin
				cmd.mul_en = 1'b1;
				cmd.ma     = MA_DRV_HI;
				cmd.mb     = MB_GAIN;
				cmd.post   = PO_ACC_LO;
			end
			S_GACC: cmd.post = PO_ACC_HI;
			S_SIN:  cmd.post = PO_SIN;
			S_SMUL: begin
				cmd.mul_en = 1'b1;
				cmd.ma     = MA_DIFF;
				cmd.mb     = MB_STAGE;
			end
			S_V:   cmd.post = PO_V;
			S_Y:   cmd.post = PO_Y;
			S_ST:  cmd.post = PO_ST;
			S_OUT: cmd.post = out_load ? PO_OUT : PO_NONE;
			default: cmd.post = PO_NONE;
		endcase
	end

endmodule

// ===== src/flp_dp.sv =====
module flp_dp #(
	parameter int SAMPLE_BITS    = flp_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = flp_pkg::COEF_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [flp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_FRAC_BITS+2:0]           cfg_data,
	input  flp_pkg::flp_cmd_t                   cmd,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	output logic signed [SAMPLE_BITS-1:0]       sample_out
);
	import flp_pkg::*;

	localparam int GAIN_W = COEF_FRAC_BITS + 1;
	localparam int RES_W  = COEF_FRAC_BITS + 3;
	localparam int MB_W   = RES_W + 1;
	localparam int P_W    = MA_W + MB_W;
	localparam int WACC_W = COEF_FRAC_BITS + 44;

	localparam logic signed [P_W-1:0]    HALF_P = P_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [WACC_W-1:0] HALF_W = WACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	localparam logic signed [STATE_W-1:0] OUT_MAX =
		STATE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [STATE_W-1:0] OUT_MIN =
		STATE_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// coefficient registers
	logic [GAIN_W-1:0] sg_q;
	logic [GAIN_W-1:0] ig_q;
	logic [RES_W-1:0]  res_q;
	logic [GAIN_W-1:0] tap_q [NUM_STAGES];

	logic signed [STATE_W-1:0]     st_q [NUM_STAGES];
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [FB_W-1:0]        fb_q;
	logic signed [P_W-1:0]         p_s1;
	logic signed [WACC_W-1:0]      wacc_q;
	logic signed [DRV_W-1:0]       drive_q;
	logic signed [STATE_W-1:0]     sin_q;
	logic signed [MA_W-1:0]        diff_q;
	logic signed [STATE_W-1:0]     v_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [P_W-1:0]     prod;
	logic signed [P_W-1:0]     rnd_p;
	logic signed [WACC_W-1:0]  wsh;
	logic signed [STATE_W-1:0] wsat;
	logic signed [STATE_W-1:0] y_val;
	logic signed [STATE_W-1:0] s_new;
	logic signed [STATE_W-1:0] out_clip;
	logic                      st_rot;

	always_comb begin
		case (cmd.ma)
			MA_ST:     mul_a = MA_W'(st_q[0]);
			MA_FB_LO:  mul_a = signed'(MA_W'(fb_q[SPLIT_W-1:0]));
			MA_FB_HI:  mul_a = MA_W'(signed'(fb_q[FB_W-1:SPLIT_W]));
			MA_DRV_LO: mul_a = signed'(MA_W'(drive_q[SPLIT_W-1:0]));
			MA_DRV_HI: mul_a = MA_W'(signed'(drive_q[DRV_W-1:SPLIT_W]));
			MA_DIFF:   mul_a = diff_q;
			default:   mul_a = diff_q;
		endcase
		case (cmd.mb)
			MB_TAP:   mul_b = signed'(MB_W'(tap_q[cmd.idx]));
			MB_RES:   mul_b = signed'(MB_W'(res_q));
			MB_GAIN:  mul_b = signed'(MB_W'(ig_q));
			MB_STAGE: mul_b = signed'(MB_W'(sg_q));
			default:  mul_b = signed'(MB_W'(sg_q));
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign rnd_p = (p_s1 + HALF_P) >>> COEF_FRAC_BITS;
	assign wsh   = wacc_q >>> COEF_FRAC_BITS;
	assign wsat  = sat32(64'(wsh));
	assign y_val = sat32(64'(v_q) + 64'(st_q[0]));
	assign s_new = sat32(64'(v_q) + 64'(sin_q));
	assign st_rot = (cmd.post == PO_ST) || (cmd.mul_en && cmd.ma == MA_ST);

	always_comb begin
		if (sin_q > OUT_MAX)
			out_clip = OUT_MAX;
		else if (sin_q < OUT_MIN)
			out_clip = OUT_MIN;
		else
			out_clip = sin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sg_q     <= GAIN_W'(coef_at(RST_STAGE_GAIN, COEF_FRAC_BITS));
			ig_q     <= GAIN_W'(coef_at(RST_INPUT_GAIN, COEF_FRAC_BITS));
			res_q    <= RES_W'(coef_at(RST_RESONANCE, COEF_FRAC_BITS));
			tap_q[0] <= GAIN_W'(coef_at(RST_TAP_ONE, COEF_FRAC_BITS));
			tap_q[1] <= GAIN_W'(coef_at(RST_TAP_TWO, COEF_FRAC_BITS));
			tap_q[2] <= GAIN_W'(coef_at(RST_TAP_THREE, COEF_FRAC_BITS));
			tap_q[3] <= GAIN_W'(coef_at(RST_TAP_FOUR, COEF_FRAC_BITS));
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STAGE_GAIN: sg_q     <= cfg_data[GAIN_W-1:0];
				REG_INPUT_GAIN: ig_q     <= cfg_data[GAIN_W-1:0];
				REG_RESONANCE:  res_q    <= cfg_data;
				REG_TAP_ONE:    tap_q[0] <= cfg_data[GAIN_W-1:0];
				REG_TAP_TWO:    tap_q[1] <= cfg_data[GAIN_W-1:0];
				REG_TAP_THREE:  tap_q[2] <= cfg_data[GAIN_W-1:0];
				REG_TAP_FOUR:   tap_q[3] <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage states rotate so that the active stage always sits at entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STAGES; i++)
				st_q[i] <= '0;
		end else if (st_rot) begin
			for (int i = 0; i < NUM_STAGES - 1; i++)
				st_q[i] <= st_q[i+1];
			st_q[NUM_STAGES-1] <= (cmd.post == PO_ST) ? s_new : st_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			p_s1 <= prod;
		case (cmd.post)
			PO_LOAD: begin
				x_q  <= sample;
				fb_q <= '0;
			end
			PO_FB_ACC: fb_q    <= fb_q + FB_W'(rnd_p);
			PO_ACC_LO: wacc_q  <= WACC_W'(p_s1) + HALF_W;
			PO_ACC_HI: wacc_q  <= wacc_q + (WACC_W'(p_s1) <<< SPLIT_W);
			PO_DRIVE:  drive_q <= DRV_W'(x_q) - DRV_W'(wsh);
			PO_SIN: begin
				sin_q  <= wsat;
				diff_q <= MA_W'(wsat) - MA_W'(st_q[0]);
			end
			PO_V: v_q   <= sat32(64'(rnd_p));
			PO_Y: sin_q <= y_val;
			PO_ST: diff_q <= MA_W'(sin_q) - MA_W'(st_q[1]);
			PO_OUT: out_q <= out_clip[SAMPLE_BITS-1:0];
			default: ;
		endcase
	end

	assign sample_out = out_q;

endmodule

// ===== src/four_pole_ladder_lowpass.sv =====
// Four-pole ladder low-pass, one shared multiplier stepped by a controller.
// A new sample is taken only in the idle state, after the previous one has passed
// through the multiply sequence of the feedback taps, two split products and four
// dependent stages and its result has been loaded into the result register.
// Reset: arst_n clears the stage states, loads the default coefficients and
// empties the result register.
module four_pole_ladder_lowpass #(
	parameter int SAMPLE_BITS    = flp_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = flp_pkg::COEF_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	flp_in_if.sink                        feed,
	flp_out_if.source                     result,
	input  logic                          cfg_wr_en,
	input  logic [flp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_FRAC_BITS+2:0]     cfg_data
);
	import flp_pkg::*;

	flp_cmd_t cmd;

	flp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed.valid),
		.feed_ready (feed.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.cmd        (cmd)
	);

	flp_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sample     (feed.sample_in),
		.sample_out (result.sample_out)
	);

endmodule

// ===== src/flp_chk.sv =====
module flp_chk #(
	parameter int SAMPLE_BITS = flp_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_data
);

	// one sample in flight: no new transfer right after one
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready after transfer");

	// fixed latency when the result register is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##31 out_valid)
		else $error("result late or missing");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without processing");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind four_pole_ladder_lowpass flp_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_flp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feed.valid),
	.in_ready  (feed.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.sample_out)
);
